@@ sv/detq_pkg.sv @@
// Shared types, constants and ring index arithmetic for the double-ended ticket queue.
// Used by detq_ctrl and double_ended_ticket_queue; no dependencies.
package detq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ACT_W = 3;
	localparam int STS_W = 3;
	localparam int TKT_W = 32;
	localparam int POS_W = 5;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DUMP_FWD   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DUMP_REV   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd6;

	localparam logic [STS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STS_W-1:0] STS_EMPTY     = 3'd1;
	localparam logic [STS_W-1:0] STS_FULL      = 3'd2;
	localparam logic [STS_W-1:0] STS_FOUND     = 3'd3;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic signed [TKT_W-1:0] ticket;
	} in_item_t;

	typedef struct packed {
		logic [STS_W-1:0]        status;
		logic signed [TKT_W-1:0] value;
		logic [POS_W-1:0]        position;
		logic                    last;
	} out_item_t;

	// Ring slot that lies off entries behind base, with off at most DEPTH.
	function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] base,
			logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ sv/detq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value in cycles without a read. No dependencies.
module detq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/detq_ctrl.sv @@
// Sequencer for the double-ended ticket queue: ring pointers, entry walk and result register.
// Depends on detq_pkg; drives the ports of one detq_ram.
module detq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  detq_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output detq_pkg::out_item_t         out_data,
	output logic                        wr_en,
	output logic [detq_pkg::IDX_W-1:0]  wr_addr,
	output logic [detq_pkg::TKT_W-1:0]  wr_data,
	output logic                        rd_en,
	output logic [detq_pkg::IDX_W-1:0]  rd_addr,
	input  logic [detq_pkg::TKT_W-1:0]  rd_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_WALK
	} state_t;

	state_t                         state_q;
	logic [detq_pkg::IDX_W-1:0]     front_q;
	logic [detq_pkg::CNT_W-1:0]     count_q;
	logic [detq_pkg::CNT_W-1:0]     idx_q;
	logic [detq_pkg::ACT_W-1:0]     act_q;
	logic [detq_pkg::TKT_W-1:0]     ticket_q;
	logic                           out_valid_q;
	detq_pkg::out_item_t            out_q;

	logic                           out_free;
	logic                           accept;
	logic                           full;
	logic                           empty;
	logic [detq_pkg::IDX_W-1:0]     front_dec;
	logic [detq_pkg::IDX_W-1:0]     front_inc;
	logic [detq_pkg::CNT_W-1:0]     count_dec;
	logic                           is_search;
	logic                           is_last;
	logic                           match;
	logic                           walk_step;
	logic [detq_pkg::CNT_W-1:0]     next_off;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == detq_pkg::CNT_W'(detq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign count_dec = count_q - detq_pkg::CNT_W'(1);
	assign front_dec = (front_q == '0) ? detq_pkg::IDX_W'(detq_pkg::DEPTH - 1)
		: front_q - detq_pkg::IDX_W'(1);
	assign front_inc = (front_q == detq_pkg::IDX_W'(detq_pkg::DEPTH - 1)) ? '0
		: front_q + detq_pkg::IDX_W'(1);

	assign is_search = (act_q == detq_pkg::ACT_SEARCH);
	assign is_last   = ((idx_q + detq_pkg::CNT_W'(1)) == count_q);
	assign match     = (rd_data == ticket_q);
	assign walk_step = (state_q == ST_WALK) && !is_last
		&& (is_search ? !match : out_free);
	assign next_off  = (act_q == detq_pkg::ACT_DUMP_REV)
		? count_q - detq_pkg::CNT_W'(2) - idx_q
		: idx_q + detq_pkg::CNT_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = detq_pkg::slot_at(front_q, count_q);
		wr_data = in_data.ticket;
		rd_en   = 1'b0;
		rd_addr = front_q;
		if (accept) begin
			unique case (in_data.action)
				detq_pkg::ACT_PUSH_FRONT: begin
					wr_en   = !full;
					wr_addr = front_dec;
				end
				detq_pkg::ACT_PUSH_REAR: begin
					wr_en = !full;
				end
				detq_pkg::ACT_POP_FRONT, detq_pkg::ACT_DUMP_FWD,
				detq_pkg::ACT_SEARCH: begin
					rd_en = !empty;
				end
				detq_pkg::ACT_POP_REAR, detq_pkg::ACT_DUMP_REV: begin
					rd_en   = !empty;
					rd_addr = detq_pkg::slot_at(front_q, count_dec);
				end
				default: begin
				end
			endcase
		end else if (walk_step) begin
			rd_en   = 1'b1;
			rd_addr = detq_pkg::slot_at(front_q, next_off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			act_q       <= '0;
			ticket_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q    <= in_data.action;
						ticket_q <= in_data.ticket;
						idx_q    <= '0;
						unique case (in_data.action)
							detq_pkg::ACT_PUSH_FRONT, detq_pkg::ACT_PUSH_REAR: begin
								out_valid_q     <= 1'b1;
								out_q.status    <= full ? detq_pkg::STS_FULL : detq_pkg::STS_OK;
								out_q.value     <= in_data.ticket;
								out_q.position  <= '0;
								out_q.last      <= 1'b1;
								if (!full) begin
									count_q <= count_q + detq_pkg::CNT_W'(1);
									if (in_data.action == detq_pkg::ACT_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
							end
							detq_pkg::ACT_POP_FRONT, detq_pkg::ACT_POP_REAR: begin
								if (empty) begin
									out_valid_q    <= 1'b1;
									out_q.status   <= detq_pkg::STS_EMPTY;
									out_q.value    <= '0;
									out_q.position <= '0;
									out_q.last     <= 1'b1;
								end else begin
									state_q <= ST_POP;
									count_q <= count_dec;
									if (in_data.action == detq_pkg::ACT_POP_FRONT) begin
										front_q <= front_inc;
									end
								end
							end
							detq_pkg::ACT_DUMP_FWD, detq_pkg::ACT_DUMP_REV,
							detq_pkg::ACT_SEARCH: begin
								if (empty) begin
									out_valid_q    <= 1'b1;
									out_q.status   <= detq_pkg::STS_EMPTY;
									out_q.value    <= (in_data.action == detq_pkg::ACT_SEARCH)
										? in_data.ticket : '0;
									out_q.position <= '0;
									out_q.last     <= 1'b1;
								end else begin
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_q.status   <= detq_pkg::STS_OK;
						out_q.value    <= rd_data;
						out_q.position <= '0;
						out_q.last     <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (walk_step) begin
						idx_q <= idx_q + detq_pkg::CNT_W'(1);
					end
					if (is_search) begin
						if (out_free && (match || is_last)) begin
							out_valid_q    <= 1'b1;
							out_q.status   <= match ? detq_pkg::STS_FOUND
								: detq_pkg::STS_NOT_FOUND;
							out_q.value    <= ticket_q;
							out_q.position <= match
								? detq_pkg::POS_W'(idx_q + detq_pkg::CNT_W'(1)) : '0;
							out_q.last     <= 1'b1;
							state_q        <= ST_IDLE;
						end
					end else if (out_free) begin
						out_valid_q    <= 1'b1;
						out_q.status   <= detq_pkg::STS_OK;
						out_q.value    <= rd_data;
						out_q.position <= '0;
						out_q.last     <= is_last;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/double_ended_ticket_queue.sv @@
// Latency: a push answers in the cycle after its transfer; a pop of a non-empty queue
// goes through ST_POP and then the result register; an empty pop answers like a push.
// Throughput: one item at a time; a dump or a search walks the stored entries through
// the single RAM read port, one entry per cycle, a dump only while results are taken.
// Reset: arst_n clears the ring pointers and entry count, so the queue starts empty;
// the ticket RAM is not cleared and needs no clearing pass.
module double_ended_ticket_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  detq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output detq_pkg::out_item_t out_data
);

	logic                        wr_en;
	logic [detq_pkg::IDX_W-1:0]  wr_addr;
	logic [detq_pkg::TKT_W-1:0]  wr_data;
	logic                        rd_en;
	logic [detq_pkg::IDX_W-1:0]  rd_addr;
	logic [detq_pkg::TKT_W-1:0]  rd_data;

	detq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	detq_ram #(
		.WIDTH  (detq_pkg::TKT_W),
		.DEPTH  (detq_pkg::DEPTH),
		.ADDR_W (detq_pkg::IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
